// File: src/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared codes, character constants and controller/datapath words for the
// console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  // Character codes the editor reacts to
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_CTRL_H = 8'h08;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_U = 8'h15;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  typedef enum logic {
    OP_RX,
    OP_READ
  } opcode_e;

  typedef enum logic [1:0] {
    ECHO_NONE,
    ECHO_BYTE,
    ECHO_ERASE
  } echo_kind_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_BYTE,
    RD_EMPTY,
    RD_EOF
  } read_status_e;

  // Which pointer drives the store read port
  typedef enum logic {
    ADDR_READ,
    ADDR_ERASE
  } addr_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      capture;
    addr_sel_e addr_sel;
    logic      exec_char;
    logic      erase_init;
    logic      erase_check;
    logic      erase_done;
    logic      exec_read;
  } cle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_read;
    logic is_kill;
    logic edit_at_commit;
    logic erase_more;
  } cle_status_t;

endpackage

// File: src/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// Sequencer: takes a word, steps the datapath through a character, a read
// or the line-kill erase loop, and strobes done when the result is loaded.
// ----------------------------------------------------------------------------
module cle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  cle_pkg::cle_status_t status_i,
  output cle_pkg::cle_cmd_t    cmd_o,
  output logic                busy_o,
  output logic                done_o
);
  import cle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAR,
    S_READ,
    S_ERASE_RD,
    S_ERASE_CHK
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.addr_sel = ADDR_READ;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = status_i.in_is_read ? S_READ : S_CHAR;
        end
      end
      S_READ: begin
        cmd_o.exec_read = 1'b1;
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      S_CHAR: begin
        if (status_i.is_kill && !status_i.edit_at_commit) begin
          // line kill: fetch the char before the edit pointer
          cmd_o.erase_init = 1'b1;
          cmd_o.addr_sel   = ADDR_ERASE;
          state_d = S_ERASE_CHK;
        end else begin
          cmd_o.exec_char = 1'b1;
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_ERASE_RD: begin
        cmd_o.addr_sel = ADDR_ERASE;
        state_d = S_ERASE_CHK;
      end
      S_ERASE_CHK: begin
        cmd_o.erase_check = 1'b1;
        if (status_i.erase_more) begin
          state_d = S_ERASE_RD;
        end else begin
          cmd_o.erase_done = 1'b1;
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// File: src/cle_datapath.sv
// ----------------------------------------------------------------------------
// cle_datapath
// Ring buffer pointers, line store, erase counter and result registers.
// ----------------------------------------------------------------------------
module cle_datapath #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cle_pkg::cle_cmd_t    cmd_i,
  output cle_pkg::cle_status_t status_o,
  input  logic                 opcode_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 first_of_request_i,
  output logic [1:0]           echo_kind_o,
  output logic [7:0]           echo_byte_o,
  output logic [7:0]           erase_count_o,
  output logic                 dump_request_o,
  output logic                 line_ready_o,
  output logic [1:0]           read_status_o,
  output logic [7:0]           read_byte_o,
  output logic                 read_ends_o
);
  import cle_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int PW = $clog2(2 * BUFFER_DEPTH);
  localparam logic [PW-1:0] PTR_MAX   = PW'(2 * BUFFER_DEPTH - 1);
  localparam logic [PW-1:0] PTR_DEPTH = PW'(BUFFER_DEPTH);
  localparam logic [PW-1:0] PTR_NEAR  = PW'(BUFFER_DEPTH - 1);
  localparam logic [PW:0]   PTR_SPAN  = (PW + 1)'(2 * BUFFER_DEPTH);

  // Pointer arithmetic modulo twice the depth
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_MAX) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PTR_MAX : p - PW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= PTR_DEPTH) ? p - PTR_DEPTH : p;
    return s[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] ptr_dist(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] t;
    t = {1'b0, a} + PTR_SPAN - {1'b0, b};
    return (a >= b) ? a - b : t[PW-1:0];
  endfunction

  logic [PW-1:0] read_q, read_d;
  logic [PW-1:0] commit_q, commit_d;
  logic [PW-1:0] edit_q, edit_d;
  logic [7:0]    cnt_q, cnt_d;
  logic [7:0]    byte_q;
  logic          first_q;

  logic [1:0] echo_kind_q, echo_kind_d;
  logic [7:0] echo_byte_q, echo_byte_d;
  logic [7:0] erase_cnt_q, erase_cnt_d;
  logic       dump_q, dump_d;
  logic       ready_q, ready_d;
  logic [1:0] status_q, status_d;
  logic [7:0] rbyte_q, rbyte_d;
  logic       rends_q, rends_d;
  logic       res_load;

  logic [PW-1:0] edit_dec;
  logic [PW-1:0] fill;
  logic [7:0]    store_byte;
  logic [7:0]    cnt_inc;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] ram_raddr;
  logic          is_erase_char;
  logic          is_printable;
  logic          store_en;
  logic          step_ok;

  // Decode of the held character
  assign edit_dec      = ptr_dec(edit_q);
  assign fill          = ptr_dist(edit_q, read_q);
  assign store_byte    = (byte_q == CH_CR) ? CH_NL : byte_q;
  assign is_erase_char = (byte_q == CH_CTRL_H) || (byte_q == CH_DEL);
  assign is_printable  = (byte_q != CH_NUL) && (byte_q != CH_CTRL_P) &&
                         (byte_q != CH_CTRL_U) && !is_erase_char;
  assign store_en      = cmd_i.exec_char && is_printable && (fill < PTR_DEPTH);
  assign cnt_inc       = (cnt_q == 8'hff) ? cnt_q : cnt_q + 8'd1;
  assign step_ok       = (ram_rdata != CH_NL);

  // Status back to the sequencer
  assign status_o.in_is_read     = (opcode_i == OP_READ);
  assign status_o.is_kill        = (byte_q == CH_CTRL_U);
  assign status_o.edit_at_commit = (edit_q == commit_q);
  assign status_o.erase_more     = step_ok && (edit_dec != commit_q);

  // Line store
  assign ram_raddr = (cmd_i.addr_sel == ADDR_READ) ? ptr_slot(read_q) : ptr_slot(edit_dec);

  cle_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (ptr_slot(edit_q)),
    .wdata_i (store_byte),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pointer updates and result words
  always_comb begin
    read_d      = read_q;
    commit_d    = commit_q;
    edit_d      = edit_q;
    cnt_d       = cnt_q;
    res_load    = 1'b0;
    echo_kind_d = ECHO_NONE;
    echo_byte_d = '0;
    erase_cnt_d = '0;
    dump_d      = 1'b0;
    ready_d     = 1'b0;
    status_d    = RD_NONE;
    rbyte_d     = '0;
    rends_d     = 1'b0;

    if (cmd_i.erase_init) begin
      cnt_d = '0;
    end

    if (cmd_i.exec_char) begin
      res_load = 1'b1;
      if (byte_q == CH_CTRL_P) begin
        dump_d = 1'b1;
      end else if (is_erase_char) begin
        if (edit_q != commit_q) begin
          edit_d      = edit_dec;
          echo_kind_d = ECHO_ERASE;
          erase_cnt_d = 8'd1;
        end
      end else if (store_en) begin
        edit_d      = ptr_inc(edit_q);
        echo_kind_d = ECHO_BYTE;
        echo_byte_d = store_byte;
        if (store_byte == CH_NL || store_byte == CH_CTRL_D || fill == PTR_NEAR) begin
          commit_d = ptr_inc(edit_q);
          ready_d  = 1'b1;
        end
      end
    end

    // one step of the line kill
    if (cmd_i.erase_check && step_ok) begin
      edit_d = edit_dec;
      cnt_d  = cnt_inc;
    end
    if (cmd_i.erase_done) begin
      res_load    = 1'b1;
      erase_cnt_d = step_ok ? cnt_inc : cnt_q;
      echo_kind_d = (erase_cnt_d != 8'd0) ? ECHO_ERASE : ECHO_NONE;
    end

    if (cmd_i.exec_read) begin
      res_load = 1'b1;
      if (read_q == commit_q) begin
        status_d = RD_EMPTY;
      end else if (ram_rdata == CH_CTRL_D) begin
        status_d = RD_EOF;
        if (first_q) begin
          read_d = ptr_inc(read_q);
        end
      end else begin
        read_d   = ptr_inc(read_q);
        status_d = RD_BYTE;
        rbyte_d  = ram_rdata;
        rends_d  = (ram_rdata == CH_NL);
      end
    end
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_q   <= '0;
      commit_q <= '0;
      edit_q   <= '0;
    end else begin
      read_q   <= read_d;
      commit_q <= commit_d;
      edit_q   <= edit_d;
    end
  end

  // Held word, erase counter and results
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (cmd_i.capture) begin
      byte_q  <= rx_byte_i;
      first_q <= first_of_request_i;
    end
    if (res_load) begin
      echo_kind_q <= echo_kind_d;
      echo_byte_q <= echo_byte_d;
      erase_cnt_q <= erase_cnt_d;
      dump_q      <= dump_d;
      ready_q     <= ready_d;
      status_q    <= status_d;
      rbyte_q     <= rbyte_d;
      rends_q     <= rends_d;
    end
  end

  assign echo_kind_o    = echo_kind_q;
  assign echo_byte_o    = echo_byte_q;
  assign erase_count_o  = erase_cnt_q;
  assign dump_request_o = dump_q;
  assign line_ready_o   = ready_q;
  assign read_status_o  = status_q;
  assign read_byte_o    = rbyte_q;
  assign read_ends_o    = rends_q;

`ifndef NO_ASSERTIONS
  // Pointers stay inside the doubled range
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_q <= PTR_MAX) && (commit_q <= PTR_MAX) && (edit_q <= PTR_MAX))
    else $error("pointer out of range");

  // Committed text never runs past the edited text
  a_commit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_dist(commit_q, read_q) <= ptr_dist(edit_q, read_q))
    else $error("commit pointer beyond edit pointer");

  // Buffer never holds more than its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_dist(edit_q, read_q) <= PTR_DEPTH)
    else $error("buffer overfilled");
`endif

endmodule

// File: src/console_line_editor_unit.sv
// A read or a plain character passes through S_READ or S_CHAR, which loads its result and done strobe together.
// A Control-U that erases characters goes from S_CHAR to S_ERASE_CHK, then through S_ERASE_RD and S_ERASE_CHK
// again for each further character. The unit is busy and takes no new word until a word is finished.
// A new word may be started in the same cycle its predecessor's result is strobed.
// Reset clears the pointers (empty buffer); store contents are left as they are.
// ----------------------------------------------------------------------------
// console_line_editor_unit
// Canonical console line editor: ring buffer of typed text with read, commit
// and edit pointers, echo and erase reporting, and committed-byte reads.
// ----------------------------------------------------------------------------
module console_line_editor_unit #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       opcode_i,
  input  logic [7:0] rx_byte_i,
  input  logic       first_of_request_i,
  output logic       done_o,
  output logic [1:0] echo_kind_o,
  output logic [7:0] echo_byte_o,
  output logic [7:0] erase_count_o,
  output logic       dump_request_o,
  output logic       line_ready_o,
  output logic [1:0] read_status_o,
  output logic [7:0] read_byte_o,
  output logic       read_ends_o
);
  import cle_pkg::*;

  cle_cmd_t    cmd;
  cle_status_t status;

  // Sequencer
  cle_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // Buffer, pointers and results
  cle_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .opcode_i           (opcode_i),
    .rx_byte_i          (rx_byte_i),
    .first_of_request_i (first_of_request_i),
    .echo_kind_o        (echo_kind_o),
    .echo_byte_o        (echo_byte_o),
    .erase_count_o      (erase_count_o),
    .dump_request_o     (dump_request_o),
    .line_ready_o       (line_ready_o),
    .read_status_o      (read_status_o),
    .read_byte_o        (read_byte_o),
    .read_ends_o        (read_ends_o)
  );

`ifndef NO_ASSERTIONS
  // A result is strobed only once the unit is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  // A taken word makes the unit busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("word taken without going busy");

  // Reads never echo
  a_read_no_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (read_status_o != RD_NONE)) |-> (echo_kind_o == ECHO_NONE))
    else $error("echo reported on a read");
`endif

endmodule

// File: test/tb_console_line_editor_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_console_line_editor_unit
// Self-checking bench for the console line editor. A short table of typed-in
// keystrokes and reads comes first. Random lines, reads, buffer fills, long
// line kills and noise words follow. Every accepted word goes through a
// shadow editor, with its own ring buffer and pointers, which predicts the
// strobed result. Results are compared field by field in the order they come.
// ----------------------------------------------------------------------------
module tb_console_line_editor_unit;
  import cle_pkg::*;

  localparam int DEPTH        = 128;
  localparam int PW           = $clog2(2 * DEPTH);
  localparam int RANDOM_WORDS = 1600;
  localparam int TAIL_CYCLES  = 2 * DEPTH + 40;

  typedef logic [PW-1:0] ptr_t;

  typedef struct packed {
    echo_kind_e   kind;
    logic [7:0]   echo;
    logic [7:0]   erase;
    logic         dump;
    logic         ready;
    read_status_e status;
    logic [7:0]   rbyte;
    logic         ends;
  } editor_result_t;

  // One word for the editor; pinned rows carry a hand-written result
  typedef struct packed {
    opcode_e        op;
    logic [7:0]     data;
    logic           first;
    logic           pinned;
    editor_result_t want;
  } key_word_t;

  localparam editor_result_t QUIET = '0;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       opcode_i = 1'b0;
  logic [7:0] rx_byte_i = 8'h00;
  logic       first_of_request_i = 1'b0;
  logic       done_o;
  logic [1:0] echo_kind_o;
  logic [7:0] echo_byte_o;
  logic [7:0] erase_count_o;
  logic       dump_request_o;
  logic       line_ready_o;
  logic [1:0] read_status_o;
  logic [7:0] read_byte_o;
  logic       read_ends_o;

  console_line_editor_unit #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .rx_byte_i          (rx_byte_i),
    .first_of_request_i (first_of_request_i),
    .done_o             (done_o),
    .echo_kind_o        (echo_kind_o),
    .echo_byte_o        (echo_byte_o),
    .erase_count_o      (erase_count_o),
    .dump_request_o     (dump_request_o),
    .line_ready_o       (line_ready_o),
    .read_status_o      (read_status_o),
    .read_byte_o        (read_byte_o),
    .read_ends_o        (read_ends_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow editor state
  logic [7:0] text_mem [DEPTH];
  ptr_t       rd_ptr = '0;
  ptr_t       cm_ptr = '0;
  ptr_t       ed_ptr = '0;

  key_word_t      key_q[$];      // words waiting to be sent
  key_word_t      in_flight_q[$]; // word on the port, not yet taken
  editor_result_t outcome_q[$];  // results owed by the editor
  int unsigned    fails = 0;
  int unsigned    burst_left = 0;

  function automatic logic [PW-2:0] slot(input ptr_t p);
    return p[PW-2:0];
  endfunction

  // Shadow editor: applies one word and returns the result it must strobe
  function automatic editor_result_t next_editor_result(input opcode_e op,
                                                        input logic [7:0] ch_in,
                                                        input logic first);
    editor_result_t r;
    logic [7:0]     ch;
    logic [7:0]     b;
    ptr_t           fill;
    int unsigned    n;
    r = QUIET;
    ch = ch_in;
    n = 0;
    fill = ed_ptr - rd_ptr;
    if (op == OP_RX) begin
      if (ch == CH_CTRL_P) begin
        r.dump = 1'b1;
      end else if (ch == CH_CTRL_U) begin
        // kill back to the commit point or the last newline
        while (ed_ptr != cm_ptr && text_mem[slot(ed_ptr - 1'b1)] != CH_NL) begin
          ed_ptr = ed_ptr - 1'b1;
          n++;
        end
        if (n > 0) begin
          r.kind = ECHO_ERASE;
          r.erase = (n > 255) ? 8'd255 : 8'(n);
        end
      end else if (ch == CH_CTRL_H || ch == CH_DEL) begin
        if (ed_ptr != cm_ptr) begin
          ed_ptr = ed_ptr - 1'b1;
          r.kind = ECHO_ERASE;
          r.erase = 8'd1;
        end
      end else if (ch != CH_NUL && fill < DEPTH) begin
        if (ch == CH_CR) ch = CH_NL;
        text_mem[slot(ed_ptr)] = ch;
        ed_ptr = ed_ptr + 1'b1;
        fill = ed_ptr - rd_ptr;
        r.kind = ECHO_BYTE;
        r.echo = ch;
        if (ch == CH_NL || ch == CH_CTRL_D || fill == DEPTH) begin
          cm_ptr = ed_ptr;
          r.ready = 1'b1;
        end
      end
    end else if (rd_ptr == cm_ptr) begin
      r.status = RD_EMPTY;
    end else begin
      b = text_mem[slot(rd_ptr)];
      if (b == CH_CTRL_D) begin
        // end of file is consumed only by the first byte of a request
        r.status = RD_EOF;
        if (first) rd_ptr = rd_ptr + 1'b1;
      end else begin
        rd_ptr = rd_ptr + 1'b1;
        r.status = RD_BYTE;
        r.rbyte = b;
        r.ends = (b == CH_NL);
      end
    end
    return r;
  endfunction

  function automatic editor_result_t mk_result(input echo_kind_e kind,
                                               input logic [7:0] echo,
                                               input logic [7:0] erase,
                                               input logic dump,
                                               input logic ready,
                                               input read_status_e status,
                                               input logic [7:0] rbyte,
                                               input logic ends);
    editor_result_t r;
    r.kind = kind;
    r.echo = echo;
    r.erase = erase;
    r.dump = dump;
    r.ready = ready;
    r.status = status;
    r.rbyte = rbyte;
    r.ends = ends;
    return r;
  endfunction

  function automatic key_word_t row(input opcode_e op, input logic [7:0] data,
                                    input logic first, input logic pinned,
                                    input editor_result_t want);
    key_word_t w;
    w.op = op;
    w.data = data;
    w.first = first;
    w.pinned = pinned;
    w.want = want;
    return w;
  endfunction

  // Unused fields get random values so they are exercised too
  function automatic key_word_t rx_word(input logic [7:0] ch);
    return row(OP_RX, ch, 1'($urandom_range(0, 1)), 1'b0, QUIET);
  endfunction

  function automatic key_word_t rd_word(input logic first);
    return row(OP_READ, 8'($urandom), first, 1'b0, QUIET);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Result check first, then word acceptance, so a result strobed in the
  // same cycle a word is taken is always matched against older words
  always @(posedge clk_i) begin : result_and_accept
    editor_result_t want;
    editor_result_t calc;
    key_word_t      w;
    if (rst_ni) begin
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          $error("result strobed with no word outstanding");
          fails++;
        end else begin
          want = outcome_q.pop_front();
          check_field("echo_kind", want.kind, echo_kind_o);
          check_field("echo_byte", want.echo, echo_byte_o);
          check_field("erase_count", want.erase, erase_count_o);
          check_field("dump_request", want.dump, dump_request_o);
          check_field("line_ready", want.ready, line_ready_o);
          check_field("read_status", want.status, read_status_o);
          check_field("read_byte", want.rbyte, read_byte_o);
          check_field("read_ends", want.ends, read_ends_o);
        end
      end
      if (start && !busy) begin
        calc = next_editor_result(opcode_e'(opcode_i), rx_byte_i, first_of_request_i);
        w = (in_flight_q.size() != 0) ? in_flight_q.pop_front() : '0;
        outcome_q.push_back(w.pinned ? w.want : calc);
      end
    end
  end

  // Send queued words in bursts with random gaps between them
  task automatic send_words();
    key_word_t   w;
    int unsigned gap;
    while (key_q.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      w = key_q.pop_front();
      in_flight_q.push_back(w);
      start <= 1'b1;
      opcode_i <= w.op;
      rx_byte_i <= w.data;
      first_of_request_i <= w.first;
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      burst_left--;
    end
  endtask

  // Hold off until every owed result has been strobed
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outcome_q.size() != 0);
  endtask

  task automatic read_request(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      key_q.push_back(rd_word(i == 0 || $urandom_range(0, 9) == 0));
  endtask

  // A typed line with some editing, usually terminated
  task automatic type_line();
    int unsigned len;
    int unsigned pick;
    logic [7:0]  ch;
    len = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) ch = CH_CTRL_H;
      else if (pick < 8) ch = CH_DEL;
      else if (pick < 11) ch = CH_CTRL_U;
      else if (pick < 13) ch = CH_CTRL_P;
      else if (pick < 15) ch = CH_NUL;
      else if (pick < 30) ch = 8'($urandom_range(1, 255));
      else ch = 8'($urandom_range(8'h20, 8'h7e));
      key_q.push_back(rx_word(ch));
    end
    pick = $urandom_range(0, 19);
    if (pick < 9) key_q.push_back(rx_word(CH_NL));
    else if (pick < 14) key_q.push_back(rx_word(CH_CR));
    else if (pick < 17) key_q.push_back(rx_word(CH_CTRL_D));
  endtask

  // Overrun the buffer with printable text, then read it back
  task automatic fill_buffer();
    repeat ($urandom_range(DEPTH + 2, DEPTH + 12))
      key_q.push_back(rx_word(8'($urandom_range(8'h20, 8'h7e))));
    read_request(DEPTH + 16);
  endtask

  initial begin : stimulus
    key_word_t   directed_tbl [26];
    int unsigned pick;
    int unsigned n_sent;
    directed_tbl = '{
      row(OP_READ, 8'hA5, 1'b1, 1'b1,
          mk_result(ECHO_NONE, 8'h00, 8'd0, 1'b0, 1'b0, RD_EMPTY, 8'h00, 1'b0)),
      row(OP_RX, CH_CTRL_H, 1'b1, 1'b1, QUIET),
      row(OP_RX, CH_DEL, 1'b0, 1'b1, QUIET),
      row(OP_RX, CH_CTRL_U, 1'b1, 1'b1, QUIET),
      row(OP_RX, CH_NUL, 1'b0, 1'b1, QUIET),
      row(OP_RX, CH_CTRL_P, 1'b1, 1'b1,
          mk_result(ECHO_NONE, 8'h00, 8'd0, 1'b1, 1'b0, RD_NONE, 8'h00, 1'b0)),
      row(OP_RX, 8'hFF, 1'b0, 1'b1,
          mk_result(ECHO_BYTE, 8'hFF, 8'd0, 1'b0, 1'b0, RD_NONE, 8'h00, 1'b0)),
      row(OP_RX, 8'h61, 1'b1, 1'b0, QUIET),
      row(OP_RX, CH_DEL, 1'b0, 1'b1,
          mk_result(ECHO_ERASE, 8'h00, 8'd1, 1'b0, 1'b0, RD_NONE, 8'h00, 1'b0)),
      row(OP_RX, 8'h01, 1'b0, 1'b0, QUIET),
      row(OP_RX, 8'h80, 1'b1, 1'b0, QUIET),
      // kill the three bytes left on the line
      row(OP_RX, CH_CTRL_U, 1'b0, 1'b1,
          mk_result(ECHO_ERASE, 8'h00, 8'd3, 1'b0, 1'b0, RD_NONE, 8'h00, 1'b0)),
      row(OP_RX, 8'h68, 1'b0, 1'b0, QUIET),
      row(OP_RX, 8'h69, 1'b1, 1'b0, QUIET),
      row(OP_RX, CH_CR, 1'b0, 1'b0, QUIET),
      // line just committed: nothing left to kill
      row(OP_RX, CH_CTRL_U, 1'b1, 1'b1, QUIET),
      row(OP_RX, 8'h78, 1'b0, 1'b0, QUIET),
      row(OP_RX, CH_CTRL_D, 1'b0, 1'b0, QUIET),
      row(OP_READ, 8'h00, 1'b1, 1'b0, QUIET),
      row(OP_READ, 8'hFF, 1'b0, 1'b0, QUIET),
      row(OP_READ, 8'h5A, 1'b0, 1'b0, QUIET),
      row(OP_READ, 8'h00, 1'b0, 1'b0, QUIET),
      // end of file inside a request stays put, first byte consumes it
      row(OP_READ, 8'h00, 1'b0, 1'b1,
          mk_result(ECHO_NONE, 8'h00, 8'd0, 1'b0, 1'b0, RD_EOF, 8'h00, 1'b0)),
      row(OP_READ, 8'hC3, 1'b0, 1'b1,
          mk_result(ECHO_NONE, 8'h00, 8'd0, 1'b0, 1'b0, RD_EOF, 8'h00, 1'b0)),
      row(OP_READ, 8'h3C, 1'b1, 1'b1,
          mk_result(ECHO_NONE, 8'h00, 8'd0, 1'b0, 1'b0, RD_EOF, 8'h00, 1'b0)),
      row(OP_READ, 8'hFF, 1'b1, 1'b1,
          mk_result(ECHO_NONE, 8'h00, 8'd0, 1'b0, 1'b0, RD_EMPTY, 8'h00, 1'b0))
    };
    n_sent = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) key_q.push_back(directed_tbl[i]);
    send_words();
    drain();

    fill_buffer();
    while (n_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        fill_buffer();
      end else if (pick < 5) begin
        // long line then kill it for a large erase count
        repeat ($urandom_range(40, 110))
          key_q.push_back(rx_word(8'($urandom_range(8'h21, 8'h7e))));
        key_q.push_back(rx_word(CH_CTRL_U));
      end else if (pick < 45) begin
        type_line();
      end else if (pick < 80) begin
        read_request($urandom_range(1, 24));
      end else begin
        repeat ($urandom_range(1, 4))
          key_q.push_back(row(opcode_e'($urandom_range(0, 1)), 8'($urandom),
                              1'($urandom_range(0, 1)), 1'b0, QUIET));
      end
      n_sent += key_q.size();
      send_words();
      if ($urandom_range(0, 29) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
src/cle_pkg.sv
src/cle_ram.sv
src/cle_ctrl.sv
src/cle_datapath.sv
src/console_line_editor_unit.sv
test/tb_console_line_editor_unit.sv
